// ===== hdl/life_grid_generation_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared concurrent-assertion shorthands, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define LFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid engine package
// Grid geometry, field widths, action and register codes, FSM states.
// ----------------------------------------------------------------------------
package lfe_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // field widths
    localparam int ACT_W   = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;

    // storage geometry
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int UR_W  = (CFG_W > $clog2(MAX_ROWS + 1)) ? CFG_W : $clog2(MAX_ROWS + 1);
    localparam int UC_W  = (CFG_W > $clog2(MAX_COLS + 1)) ? CFG_W : $clog2(MAX_COLS + 1);

    // generation walk: one row read per cycle, new row written two rows behind
    localparam int WJ_W    = $clog2(MAX_ROWS + 2);
    localparam int WJ_LAST = MAX_ROWS + 1;

    // result queue
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    localparam int GRID_RESET = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // row store access request
    typedef struct packed {
        logic                we;
        logic [ROW_W-1:0]    waddr;
        logic                wfull;   // write whole row, ignore wsel
        logic [MAX_COLS-1:0] wsel;    // single-cell select
        logic [MAX_COLS-1:0] wdata;
        logic                re;
        logic [ROW_W-1:0]    raddr;
    } t_mem_req;

endpackage

// ===== hdl/lfe_in_if.sv =====
// ----------------------------------------------------------------------------
// Life grid engine input channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface lfe_in_if import lfe_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);

endinterface

// ===== hdl/lfe_out_if.sv =====
// ----------------------------------------------------------------------------
// Life grid engine output channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface lfe_out_if import lfe_pkg::*; ();

    logic valid;
    logic ready;
    logic cell_value;
    logic bad_coordinate;

    modport source (output valid, cell_value, bad_coordinate, input ready);
    modport sink   (input valid, cell_value, bad_coordinate, output ready);

endinterface

// ===== hdl/lfe_row_mem.sv =====
// ----------------------------------------------------------------------------
// Life grid row store
// One row per entry, one write and one read port, registered read.
// Per-row valid bits give all-dead rows after reset without a clear pass.
// ----------------------------------------------------------------------------
module lfe_row_mem import lfe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_req            i_req,
    output logic [MAX_COLS-1:0] o_rd_data
);

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_vld;
    logic [MAX_COLS-1:0] r_rd_raw;
    logic                r_rd_vld;
    logic [MAX_COLS-1:0] wmask;

    // first write into a stale row stores the whole row (data is zero elsewhere)
    assign wmask = (i_req.wfull || !r_vld[i_req.waddr]) ? '1 : i_req.wsel;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            for (int b = 0; b < MAX_COLS; b++) begin
                if (wmask[b]) begin
                    r_mem[i_req.waddr][b] <= i_req.wdata[b];
                end
            end
        end
        if (i_req.re) begin
            r_rd_raw <= r_mem[i_req.raddr];
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

// ===== hdl/lfe_gen_row.sv =====
// ----------------------------------------------------------------------------
// Life grid next-row logic
// B3/S23 rule for one full row from the three old rows around it.
// ----------------------------------------------------------------------------
module lfe_gen_row import lfe_pkg::*; (
    input  logic [MAX_COLS-1:0] i_above,
    input  logic [MAX_COLS-1:0] i_mid,
    input  logic [MAX_COLS-1:0] i_below,
    input  logic                i_row_interior,
    input  logic [UC_W-1:0]     i_used_cols,
    output logic [MAX_COLS-1:0] o_row
);

    logic [MAX_COLS+1:0] above_p;
    logic [MAX_COLS+1:0] mid_p;
    logic [MAX_COLS+1:0] below_p;

    assign above_p = {1'b0, i_above, 1'b0};
    assign mid_p   = {1'b0, i_mid,   1'b0};
    assign below_p = {1'b0, i_below, 1'b0};

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
        logic [3:0] n;
        logic       alive;
        logic       col_int;

        // lane c sits at padded position c+1
        assign n = 4'(above_p[c]) + 4'(above_p[c+1]) + 4'(above_p[c+2])
                 + 4'(mid_p[c])                      + 4'(mid_p[c+2])
                 + 4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
        assign alive   = mid_p[c+1];
        assign col_int = (c >= 1) && (UC_W'(c + 1) < i_used_cols);
        assign o_row[c] = i_row_interior && col_int
                          && ((n == 4'd3) || (alive && (n == 4'd2)));
    end

endmodule

// ===== hdl/life_grid_generation_engine_core.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine
// Conway B3/S23 grid with cell write, cell read and generation advance.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : command beats (action, row, col, value), valid/ready.
//   o_out : one result beat per command (cell_value, bad_coordinate).
//   i_cfg_*: grid_rows (index 0) and grid_cols (index 1), written while idle.
// Throughput:
//   Cell write and read take one beat per cycle while idle and the result
//   queue has room; the result passes the registered row store read and
//   cell stage, then the result queue. An advance walks the row store one
//   row per cycle through its single read port, i_in held not ready
//   meanwhile; its result beat is queued at the end of the walk.
// Reset:
//   Synchronous, active low. Grid reads as all dead (per-row valid bits),
//   both size registers return to 64. No clearing pass.
// Back-pressure:
//   A 4-deep result queue decouples o_out; i_in stays ready while the queue
//   has room for every beat in flight, so a stalled receiver only stops
//   intake once the queue fills.
// ----------------------------------------------------------------------------
`include "life_grid_generation_engine_core_defines.svh"

module life_grid_generation_engine_core import lfe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lfe_in_if.sink               i_in,
    lfe_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_W'(GRID_RESET);
            r_grid_cols <= CFG_W'(GRID_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // oversized register clamps to the storage size
    logic [UR_W-1:0] rows_ext;
    logic [UC_W-1:0] cols_ext;
    logic [UR_W-1:0] used_rows;
    logic [UC_W-1:0] used_cols;

    assign rows_ext  = UR_W'(r_grid_rows);
    assign cols_ext  = UC_W'(r_grid_cols);
    assign used_rows = (rows_ext > UR_W'(MAX_ROWS)) ? UR_W'(MAX_ROWS) : rows_ext;
    assign used_cols = (cols_ext > UC_W'(MAX_COLS)) ? UC_W'(MAX_COLS) : cols_ext;

    // ---------------- input decode ----------------
    logic            in_acc;
    logic            is_write;
    logic            is_read;
    logic            is_adv;
    logic            bad_in;
    logic [UR_W-1:0] row_ext;
    logic [UC_W-1:0] col_ext;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;

    assign in_acc   = i_in.valid && i_in.ready;
    assign is_write = (i_in.action == ACT_WRITE);
    assign is_read  = (i_in.action == ACT_READ);
    assign is_adv   = (i_in.action == ACT_ADVANCE);
    assign row_ext  = UR_W'(i_in.row);
    assign col_ext  = UC_W'(i_in.col);
    assign bad_in   = (row_ext >= used_rows) || (col_ext >= used_cols);
    // in range implies below the storage size, so the low bits address it
    assign in_row   = row_ext[ROW_W-1:0];
    assign in_col   = col_ext[COL_W-1:0];

    // ---------------- walk control ----------------
    t_state          r_state;
    t_state          n_state;
    logic [WJ_W-1:0] r_j;
    logic            walk_re;
    logic            walk_we;
    logic            walk_done;
    logic            space_ok;
    logic            idle;

    logic [FQ_AW:0]  r_fq_cnt;
    logic            r_s1_v;

    assign space_ok = ((r_fq_cnt + (FQ_AW + 1)'(r_s1_v)) < (FQ_AW + 1)'(FQ_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc && is_adv) n_state = ST_WALK;
            ST_WALK: if (r_j == WJ_W'(WJ_LAST)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        idle      = 1'b0;
        walk_re   = 1'b0;
        walk_we   = 1'b0;
        walk_done = 1'b0;
        unique case (r_state)
            ST_IDLE: idle = 1'b1;
            ST_WALK: begin
                walk_re   = (r_j < WJ_W'(MAX_ROWS));
                walk_we   = (r_j >= WJ_W'(2));
                walk_done = (r_j == WJ_W'(WJ_LAST));
            end
            default: ;
        endcase
    end

    assign i_in.ready = idle && space_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_WALK) begin
                r_j <= r_j + WJ_W'(1);
            end else begin
                r_j <= '0;
            end
        end
    end

    // ---------------- row window and new row ----------------
    // read data at step j is old row j-1; the new row written is j-2
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_mid;
    logic [MAX_COLS-1:0] new_row;
    logic [WJ_W-1:0]     wj;
    logic [ROW_W-1:0]    wrow;
    logic                row_int;

    assign wj      = r_j - WJ_W'(2);
    assign wrow    = wj[ROW_W-1:0];
    assign row_int = (wrow != '0) && ((UR_W'(wrow) + UR_W'(1)) < used_rows);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WALK) begin
            r_above <= r_mid;
            r_mid   <= rd_data;
        end
    end

    lfe_gen_row u_gen (
        .i_above        (r_above),
        .i_mid          (r_mid),
        .i_below        (rd_data),
        .i_row_interior (row_int),
        .i_used_cols    (used_cols),
        .o_row          (new_row)
    );

    // ---------------- row store access ----------------
    t_mem_req            mreq;
    logic [MAX_COLS-1:0] cell_sel;

    assign cell_sel = MAX_COLS'(1) << in_col;

    always_comb begin
        if (r_state == ST_WALK) begin
            mreq.we    = walk_we;
            mreq.waddr = wrow;
            mreq.wfull = 1'b1;
            mreq.wsel  = '0;
            mreq.wdata = new_row;
            mreq.re    = walk_re;
            mreq.raddr = r_j[ROW_W-1:0];
        end else begin
            mreq.we    = in_acc && is_write && !bad_in;
            mreq.waddr = in_row;
            mreq.wfull = 1'b0;
            mreq.wsel  = cell_sel;
            mreq.wdata = i_in.value ? cell_sel : '0;
            mreq.re    = in_acc && is_read;
            mreq.raddr = in_row;
        end
    end

    lfe_row_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mreq),
        .o_rd_data (rd_data)
    );

    // ---------------- cell result stage ----------------
    logic             r_s1_rd;
    logic             r_s1_bad;
    logic [COL_W-1:0] r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            // an advance reports from the walk end instead
            r_s1_v <= in_acc && !is_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd  <= is_read && !bad_in;
            r_s1_bad <= (is_read || is_write) && bad_in;
            r_s1_col <= in_col;
        end
    end

    // ---------------- result queue ----------------
    logic             r_fq_cell [FQ_DEPTH];
    logic             r_fq_bad  [FQ_DEPTH];
    logic [FQ_AW-1:0] r_fq_wp;
    logic [FQ_AW-1:0] r_fq_rp;
    logic             push;
    logic             pop;
    logic             push_cell;
    logic             push_bad;

    assign push      = r_s1_v || walk_done;
    assign push_cell = r_s1_v && r_s1_rd && rd_data[r_s1_col];
    assign push_bad  = r_s1_v && r_s1_bad;
    assign pop       = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fq_cell[r_fq_wp] <= push_cell;
            r_fq_bad[r_fq_wp]  <= push_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fq_wp  <= '0;
            r_fq_rp  <= '0;
            r_fq_cnt <= '0;
        end else begin
            if (push) r_fq_wp <= r_fq_wp + FQ_AW'(1);
            if (pop)  r_fq_rp <= r_fq_rp + FQ_AW'(1);
            r_fq_cnt <= r_fq_cnt + (FQ_AW + 1)'(push) - (FQ_AW + 1)'(pop);
        end
    end

    assign o_out.valid          = (r_fq_cnt != '0);
    assign o_out.cell_value     = r_fq_cell[r_fq_rp];
    assign o_out.bad_coordinate = r_fq_bad[r_fq_rp];

    // ---------------- checks ----------------
    `LFE_ASSERT_NOW(a_fq_no_overflow, push && !pop, r_fq_cnt < (FQ_AW + 1)'(FQ_DEPTH), "result queue overflow")
    `LFE_ASSERT_NOW(a_mem_no_collide, mreq.we && mreq.re, mreq.waddr != mreq.raddr, "row store read/write collide")
    `LFE_ASSERT_NXT(a_adv_starts_walk, in_acc && is_adv, (r_state == ST_WALK) && (r_j == '0), "advance did not start walk")
    `LFE_ASSERT_NXT(a_walk_ends, walk_done, (r_state == ST_IDLE) && (r_fq_cnt != '0), "walk end lost result")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Walks a short directed table, then random phases of cell write, cell read
// and generation advance commands under several grid sizes. Every result beat
// is checked field by field against the table or a B3/S23 predictor tracking
// each accepted command, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench import lfe_pkg::*; ();

    // action code with no operation behind it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_CYCLES    = 48;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // result path: cell stage, then queue
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;  // longer than an advance walk
    localparam int PRINT_CAP      = 50;

    localparam logic TYPED = 1'b1;  // expectation taken from the table row
    localparam logic PRED  = 1'b0;  // expectation taken from the predictor

    typedef struct packed {
        logic cell_bit;
        logic bad;
    } t_life_result;

    typedef enum logic {
        STEP_CMD,
        STEP_REG
    } t_step_kind;

    typedef struct packed {
        t_step_kind           kind;
        logic [ACT_W-1:0]     act;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic                 value;
        logic                 typed;
        logic                 cell_bit;
        logic                 bad;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
    } t_dir_step;

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    lfe_in_if  cmd_if ();
    lfe_out_if rsp_if ();

    life_grid_generation_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: current generation and the two size registers
    // ------------------------------------------------------------------------
    logic [MAX_COLS-1:0] life_q [MAX_ROWS];
    logic [CFG_W-1:0]    rows_cfg;
    logic [CFG_W-1:0]    cols_cfg;

    t_life_result pending_results [$];
    t_dir_step    dir_steps [$];
    int           err_count    = 0;
    int           stall_cycles = 0;

    // shared between stimulus and the result sink
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    // typed expectation travelling alongside the command beat
    logic cmd_typed;
    logic cmd_typed_cell;
    logic cmd_typed_bad;

    // oversized register values clamp to the storage size
    function automatic int unsigned used_extent(input logic [CFG_W-1:0] reg_val,
                                                input int unsigned cap);
        return (reg_val > cap) ? cap : reg_val;
    endfunction

    // B3/S23 over the interior of the grid in use; border and unused cells
    // come out dead, live border cells still count as neighbours
    function automatic void step_generation();
        logic [MAX_COLS-1:0] nxt [MAX_ROWS];
        int                  nr;
        int                  nc;
        int                  n;
        nr = int'(used_extent(rows_cfg, MAX_ROWS));
        nc = int'(used_extent(cols_cfg, MAX_COLS));
        for (int r = 0; r < MAX_ROWS; r++) nxt[r] = '0;
        for (int r = 1; r + 1 < nr; r++) begin
            for (int c = 1; c + 1 < nc; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) n += int'(life_q[r + dr][c + dc]);
                    end
                end
                nxt[r][c] = life_q[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        life_q = nxt;
    endfunction

    function automatic t_life_result predict_life_cmd(input logic [ACT_W-1:0]   act,
                                                      input logic [COORD_W-1:0] r,
                                                      input logic [COORD_W-1:0] c,
                                                      input logic               v);
        t_life_result res;
        int unsigned  nr;
        int unsigned  nc;
        res = '0;
        nr  = used_extent(rows_cfg, MAX_ROWS);
        nc  = used_extent(cols_cfg, MAX_COLS);
        if (act == ACT_WRITE || act == ACT_READ) begin
            // out-of-grid coordinate: write dropped, read returns dead
            if (r >= nr || c >= nc) begin
                res.bad = 1'b1;
            end else if (act == ACT_WRITE) begin
                life_q[r][c] = v;
            end else begin
                res.cell_bit = life_q[r][c];
            end
        end else if (act == ACT_ADVANCE) begin
            step_generation();
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic got, input logic exp);
        if (err_count < PRINT_CAP)
            $display("%0t: mismatch on %s: got %b, expected %b", $time, field, got, exp);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: tracks register writes, predicts on each accepted command beat
    // and checks each accepted result beat against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_life_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_ROWS; r++) life_q[r] = '0;
            rows_cfg = CFG_W'(GRID_RESET);
            cols_cfg = CFG_W'(GRID_RESET);
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_GRID_ROWS) rows_cfg = cfg_data;
                else if (cfg_idx == CFG_GRID_COLS) cols_cfg = cfg_data;
            end
            if (cmd_if.valid && cmd_if.ready) begin
                want = predict_life_cmd(cmd_if.action, cmd_if.row, cmd_if.col, cmd_if.value);
                if (cmd_typed) begin
                    want.cell_bit = cmd_typed_cell;
                    want.bad      = cmd_typed_bad;
                end
                pending_results.push_back(want);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", rsp_if.valid, 1'b0);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.cell_value !== want.cell_bit)
                        report_mismatch("cell_value", rsp_if.cell_value, want.cell_bit);
                    if (rsp_if.bad_coordinate !== want.bad)
                        report_mismatch("bad_coordinate", rsp_if.bad_coordinate, want.bad);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no beat on either channel and no register write
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (cmd_if.valid && cmd_if.ready)
            || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: draws a random wait after each beat (none when no_idle is set);
    // on request it holds ready low for a long stretch so the result queue fills
    // and the block stops taking commands.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap_left;
        int unsigned hold_left;
        bit          took;
        gap_left  = 0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            took = rsp_if.valid && rsp_if.ready;
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (took) gap_left = no_idle ? 0 : $urandom_range(0, 8);
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void tab_cmd(input logic [ACT_W-1:0] act, input int r, input int c,
                                    input int v, input logic typed,
                                    input int cell_exp, input int bad_exp);
        t_dir_step s;
        s          = '0;
        s.kind     = STEP_CMD;
        s.act      = act;
        s.row      = COORD_W'(r);
        s.col      = COORD_W'(c);
        s.value    = 1'(v);
        s.typed    = typed;
        s.cell_bit = 1'(cell_exp);
        s.bad      = 1'(bad_exp);
        dir_steps.push_back(s);
    endfunction

    function automatic void tab_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_dir_step s;
        s          = '0;
        s.kind     = STEP_REG;
        s.reg_idx  = idx;
        s.reg_data = CFG_W'(data);
        dir_steps.push_back(s);
    endfunction

    // one command beat: random lead-in gap, then hold valid until taken
    task automatic drive_cmd(input logic [ACT_W-1:0] act, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] c, input logic v,
                             input logic typed, input logic cell_exp, input logic bad_exp);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.action  <= act;
        cmd_if.row     <= r;
        cmd_if.col     <= c;
        cmd_if.value   <= v;
        cmd_typed      <= typed;
        cmd_typed_cell <= cell_exp;
        cmd_typed_bad  <= bad_exp;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
    endtask

    // stop offering and wait until every expected result beat is back
    task automatic drain_results();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                 phase;
        int                 sent;
        int                 n_items;
        int unsigned        nr;
        int unsigned        nc;
        int unsigned        pick;
        logic [CFG_W-1:0]   rows_pick;
        logic [CFG_W-1:0]   cols_pick;
        logic [ACT_W-1:0]   act;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic               v;

        cmd_if.valid   <= 1'b0;
        cmd_if.action  <= ACT_WRITE;
        cmd_if.row     <= '0;
        cmd_if.col     <= '0;
        cmd_if.value   <= 1'b0;
        cmd_typed      <= PRED;
        cmd_typed_cell <= 1'b0;
        cmd_typed_bad  <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_GRID_ROWS;
        cfg_data       <= '0;
        i_rst_n        <= 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed table, 64 x 64 after reset ---
        tab_cmd(ACT_READ,    0,  0, 0, TYPED, 0, 0);  // grid starts dead
        tab_cmd(ACT_WRITE,  63, 63, 1, TYPED, 0, 0);  // far corner, border
        tab_cmd(ACT_READ,   63, 63, 0, TYPED, 1, 0);
        tab_cmd(ACT_WRITE,  63, 63, 0, TYPED, 0, 0);
        tab_cmd(ACT_READ,   63, 63, 0, TYPED, 0, 0);
        // three live cells on the top border give birth just below
        tab_cmd(ACT_WRITE,   0,  5, 1, TYPED, 0, 0);
        tab_cmd(ACT_WRITE,   0,  6, 1, TYPED, 0, 0);
        tab_cmd(ACT_WRITE,   0,  7, 1, TYPED, 0, 0);
        tab_cmd(ACT_UNUSED, 63, 63, 1, TYPED, 0, 0);  // no-op action
        tab_cmd(ACT_ADVANCE, 0,  0, 0, TYPED, 0, 0);
        tab_cmd(ACT_READ,    1,  6, 0, PRED,  0, 0);
        tab_cmd(ACT_READ,    0,  6, 0, TYPED, 0, 0);  // border cleared
        // 10 x 12 grid: coordinates past the edge, then a blinker
        tab_reg(CFG_GRID_ROWS, 10);
        tab_reg(CFG_GRID_COLS, 12);
        tab_cmd(ACT_WRITE,  10,  0, 1, TYPED, 0, 1);
        tab_cmd(ACT_READ,    0, 12, 0, TYPED, 0, 1);
        tab_cmd(ACT_WRITE,   5,  5, 1, TYPED, 0, 0);
        tab_cmd(ACT_WRITE,   5,  6, 1, TYPED, 0, 0);
        tab_cmd(ACT_WRITE,   5,  7, 1, TYPED, 0, 0);
        tab_cmd(ACT_ADVANCE, 0,  0, 0, TYPED, 0, 0);
        tab_cmd(ACT_READ,    4,  6, 0, PRED,  0, 0);
        tab_cmd(ACT_READ,    5,  5, 0, PRED,  0, 0);
        // oversized rows clamp to 64; two columns leave no interior
        tab_reg(CFG_GRID_ROWS, 127);
        tab_reg(CFG_GRID_COLS, 2);
        tab_cmd(ACT_READ,   63,  1, 0, PRED,  0, 0);
        tab_cmd(ACT_READ,    5,  2, 0, TYPED, 0, 1);
        tab_cmd(ACT_ADVANCE, 0,  0, 0, TYPED, 0, 0);
        tab_reg(CFG_GRID_COLS, 64);
        tab_cmd(ACT_READ,    4,  6, 0, PRED,  0, 0);
        tab_cmd(ACT_READ,    0,  0, 0, PRED,  0, 0);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_REG) begin
                drain_results();
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_data);
            end else begin
                drive_cmd(dir_steps[i].act, dir_steps[i].row, dir_steps[i].col,
                          dir_steps[i].value, dir_steps[i].typed,
                          dir_steps[i].cell_bit, dir_steps[i].bad);
            end
        end

        // --- random phases: one grid size per phase ---
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            unique case (phase)
                0: begin rows_pick = 3;   cols_pick = 64;  end
                1: begin rows_pick = 64;  cols_pick = 3;   end
                2: begin rows_pick = 0;   cols_pick = 127; end
                3: begin rows_pick = 127; cols_pick = 1;   end
                4: begin rows_pick = 65;  cols_pick = 2;   end
                default: begin
                    // mostly small grids so patterns stay dense and live
                    if ($urandom_range(0, 9) == 0)
                        rows_pick = CFG_W'($urandom_range(0, 127));
                    else if ($urandom_range(0, 3) == 0)
                        rows_pick = CFG_W'($urandom_range(3, 64));
                    else
                        rows_pick = CFG_W'($urandom_range(3, 12));
                    if ($urandom_range(0, 9) == 0)
                        cols_pick = CFG_W'($urandom_range(0, 127));
                    else if ($urandom_range(0, 3) == 0)
                        cols_pick = CFG_W'($urandom_range(3, 64));
                    else
                        cols_pick = CFG_W'($urandom_range(3, 12));
                end
            endcase
            write_reg(CFG_GRID_ROWS, rows_pick);
            write_reg(CFG_GRID_COLS, cols_pick);
            nr = used_extent(rows_pick, MAX_ROWS);
            nc = used_extent(cols_pick, MAX_COLS);

            // every fourth phase runs back to back on both sides
            no_idle = (phase % 4 == 3);
            n_items = $urandom_range(20, 50);
            for (int k = 0; k < n_items; k++) begin
                // burst phase with the receiver stalled: queue fills up
                if (phase == 7 && k == 0) hold_off_req = 1'b1;
                // mid-phase pause until all results are back
                if (phase == 8 && k == n_items / 2) drain_results();

                pick = $urandom_range(0, 99);
                if (pick < 45)      act = ACT_WRITE;
                else if (pick < 83) act = ACT_READ;
                else if (pick < 97) act = ACT_ADVANCE;
                else                act = ACT_UNUSED;

                if (nr == 0 || nc == 0 || $urandom_range(0, 6) == 0) begin
                    r = COORD_W'($urandom_range(0, 63));
                    c = COORD_W'($urandom_range(0, 63));
                end else begin
                    r = COORD_W'($urandom_range(0, nr - 1));
                    c = COORD_W'($urandom_range(0, nc - 1));
                end
                v = ($urandom_range(0, 9) < 6);

                drive_cmd(act, r, c, v, PRED, 1'b0, 1'b0);
                sent++;
            end
            no_idle = 1'b0;
            phase++;
        end

        // --- wind down ---
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
